### rtl/ird_pkg.sv
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types and codes of the id registration table: request and reply
// codes, field widths and the status struct of the slot scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ird_pkg;

  // default number of table slots
  localparam int unsigned TableDepthDef = 128;

  // field widths
  localparam int unsigned IdW    = 31;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned CodeW  = 2;
  // one slot word is a valid flag over the identifier
  localparam int unsigned SlotW  = IdW + 1;

  // request codes
  localparam logic [ReqW-1:0] REQ_ADD    = 2'd0;
  localparam logic [ReqW-1:0] REQ_CHECK  = 2'd1;
  localparam logic [ReqW-1:0] REQ_DELETE = 2'd2;
  localparam logic [ReqW-1:0] REQ_NONE   = 2'd3;

  // reply kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // reply codes
  localparam logic [CodeW-1:0] ADD_OK      = 2'd0;
  localparam logic [CodeW-1:0] ADD_DUP     = 2'd1;
  localparam logic [CodeW-1:0] ADD_FULL    = 2'd2;
  localparam logic [CodeW-1:0] CHK_ABSENT  = 2'd0;
  localparam logic [CodeW-1:0] CHK_PRESENT = 2'd1;

  // scan unit status toward the sequencer
  typedef struct packed {
    logic hit_found;
    logic free_found;
  } scan_stat_t;

endpackage

`default_nettype wire

### rtl/ird_ram.sv
// ----------------------------------------------------------------------------
// ird_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ird_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/ird_scan.sv
// ----------------------------------------------------------------------------
// ird_scan
// Slot scan unit: one identifier compare per cycle over the slot words read
// from the table, remembering the first matching slot and the first free one.
// ----------------------------------------------------------------------------
`default_nettype none

module ird_scan
  import ird_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          slot_vld_i,
  input  wire logic [$clog2(TableDepth)-1:0] slot_idx_i,
  input  wire logic [SlotW-1:0]              slot_data_i,
  input  wire logic [IdW-1:0]                pid_i,
  output      scan_stat_t                    stat_o,
  output      logic [$clog2(TableDepth)-1:0] hit_slot_o,
  output      logic [$clog2(TableDepth)-1:0] free_slot_o
);

  localparam int unsigned AW = $clog2(TableDepth);

  scan_stat_t    stat_q, stat_d;
  logic [AW-1:0] hit_slot_q, hit_slot_d;
  logic [AW-1:0] free_slot_q, free_slot_d;
  logic          slot_used;
  logic          id_match;

  assign slot_used = slot_data_i[SlotW-1];
  assign id_match  = (slot_data_i[IdW-1:0] == pid_i);

  // compare and first-hit / first-free tracking
  always_comb begin
    stat_d      = stat_q;
    hit_slot_d  = hit_slot_q;
    free_slot_d = free_slot_q;
    if (start_i) begin
      stat_d = '0;
    end else if (slot_vld_i) begin
      if (slot_used && id_match && !stat_q.hit_found) begin
        stat_d.hit_found = 1'b1;
        hit_slot_d       = slot_idx_i;
      end
      if (!slot_used && !stat_q.free_found) begin
        stat_d.free_found = 1'b1;
        free_slot_d       = slot_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
    end else begin
      stat_q <= stat_d;
    end
  end

  // slot indexes are payload
  always_ff @(posedge clk_i) begin
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
  end

  assign stat_o      = stat_q;
  assign hit_slot_o  = hit_slot_q;
  assign free_slot_o = free_slot_q;

endmodule

`default_nettype wire

### rtl/id_registration_table.sv
// ----------------------------------------------------------------------------
// id_registration_table
// Table of registered process identifiers with add, check and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries req_type_i and
//   process_id_i; output channel (out_valid_o / out_ready_i) carries
//   reply_kind_o and reply_code_o. Add and check give one reply item,
//   delete and request type three give none.
//   Every add, check and delete request walks all slots of the table RAM,
//   one slot compared per cycle; a reply (or the delete's table write)
//   lands at the end of the walk, and in_ready_o then returns. Request type
//   three does not walk the table. One request is in work at a time.
//   After reset the block sweeps the table RAM, clearing one slot per
//   cycle, before in_ready_o first rises.
//   The reply sits in an output register; a new request may be accepted
//   while it waits. If the receiver still stalls when the next reply is
//   ready, the block holds at the end of its walk until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module id_registration_table
  import ird_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [ReqW-1:0]  req_type_i,
  input  wire logic [IdW-1:0]   process_id_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic             reply_kind_o,
  output      logic [CodeW-1:0] reply_code_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthCnt = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    used_q, used_d;
  logic [ReqW-1:0]  req_q, req_d;
  logic [IdW-1:0]   pid_q, pid_d;
  logic             rd_pend_q;
  logic [AW-1:0]    rd_slot_q;
  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  logic [CodeW-1:0] code_q, code_d;

  logic             accept;
  logic             rd_en;
  logic             scan_done;
  logic             need_reply;
  logic             go;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SlotW-1:0] ram_wdata;
  logic [SlotW-1:0] ram_rdata;
  scan_stat_t       stat;
  logic [AW-1:0]    hit_slot;
  logic [AW-1:0]    free_slot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // slot read issue during the walk
  assign rd_en      = (state_q == ST_SCAN) && (cnt_q != DepthCnt);
  assign scan_done  = (state_q == ST_SCAN) && (cnt_q == DepthCnt) && !rd_pend_q;
  assign need_reply = (req_q == REQ_ADD) || (req_q == REQ_CHECK);
  assign go         = scan_done && (!need_reply || !out_valid_q || out_ready_i);

  // table RAM
  ird_ram #(
    .Width (SlotW),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // shared compare unit
  ird_scan #(
    .TableDepth (TABLE_DEPTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .slot_vld_i  (rd_pend_q),
    .slot_idx_i  (rd_slot_q),
    .slot_data_i (ram_rdata),
    .pid_i       (pid_q),
    .stat_o      (stat),
    .hit_slot_o  (hit_slot),
    .free_slot_o (free_slot)
  );

  // sequencer next state, table update and reply
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    req_d       = req_q;
    pid_d       = pid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    code_d      = code_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[AW-1:0];
    ram_wdata   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_q[AW-1:0] == LastSlot) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_d = req_type_i;
          pid_d = process_id_i;
          cnt_d = '0;
          if (req_type_i != REQ_NONE) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (go) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
          unique case (req_q)
            REQ_ADD: begin
              out_valid_d = 1'b1;
              kind_d      = KIND_ADD;
              if (stat.hit_found) begin
                code_d = ADD_DUP;
              end else if (stat.free_found && (used_q < DepthCnt)) begin
                ram_we    = 1'b1;
                ram_waddr = free_slot;
                ram_wdata = {1'b1, pid_q};
                used_d    = used_q + CW'(1);
                code_d    = ADD_OK;
              end else begin
                code_d = ADD_FULL;
              end
            end
            REQ_CHECK: begin
              out_valid_d = 1'b1;
              kind_d      = KIND_CHECK;
              code_d      = stat.hit_found ? CHK_PRESENT : CHK_ABSENT;
            end
            REQ_DELETE: begin
              if (stat.hit_found) begin
                ram_we    = 1'b1;
                ram_waddr = hit_slot;
                ram_wdata = {1'b0, pid_q};
                if (used_q != '0) begin
                  used_d = used_q - CW'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state, counters and reply register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      used_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      rd_pend_q   <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  // request and reply payload
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    pid_q     <= pid_d;
    rd_slot_q <= cnt_q[AW-1:0];
    kind_q    <= kind_d;
    code_q    <= code_d;
  end

  assign out_valid_o  = out_valid_q;
  assign reply_kind_o = kind_q;
  assign reply_code_o = code_q;

`ifndef SYNTHESIS
  // the slot count never exceeds the table size
  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= DepthCnt)
    else $error("entry count above table depth");

  // the table is written only during the clearing sweep or at the end of a walk
  a_write_when : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR) || scan_done)
    else $error("table write outside sweep or walk end");

  // a new reply appears only right after a walk has finished
  a_reply_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(scan_done))
    else $error("reply without a finished walk");

  // an accepted add, check or delete leaves the block busy on the next cycle
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i != REQ_NONE)) |=> !in_ready_o)
    else $error("ready while a request is in work");
`endif

endmodule

`default_nettype wire
